// ----- design/rdiv_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rdiv_pkg
// Types and constants shared by the restoring divider and its cells.
// ----------------------------------------------------------------------------
package rdiv_pkg;

	localparam int unsigned NumW = 32;
	localparam int unsigned DenW = 16;
	localparam int unsigned RemW = DenW + 1;

	// Command codes. Only bit 1 is decoded as "signed", so the unused code
	// behaves as signed 16/16.
	typedef enum logic [1:0] {
		CMD_U16 = 2'd0,
		CMD_U32 = 2'd1,
		CMD_S16 = 2'd2,
		CMD_RSV = 2'd3
	} cmd_e;

	typedef struct packed {
		logic [1:0]      command;
		logic [NumW-1:0] dividend;
		logic [DenW-1:0] divisor;
	} req_t;

	typedef struct packed {
		logic [DenW-1:0] quotient;
		logic [DenW-1:0] remainder;
		logic            valid_result;
	} rsp_t;

	// Work carried from cell to cell.
	typedef struct packed {
		logic            vld;
		logic [RemW-1:0] rem;
		logic [DenW-1:0] quo;
		logic [NumW-1:0] num;
		logic [DenW-1:0] dvs;
		logic            neg_q;
		logic            neg_r;
		logic            ok;
	} cell_t;

endpackage
`default_nettype wire

// ----- design/rdiv_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rdiv_cell
// One restoring step: shift in a dividend bit, compare, subtract, register.
// ----------------------------------------------------------------------------
module rdiv_cell (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            adv,
	input  rdiv_pkg::cell_t din,
	output rdiv_pkg::cell_t dout
);
	import rdiv_pkg::*;

	logic [RemW-1:0] rem_sh;
	logic            ge;
	cell_t           nxt;
	logic            vld_q;
	cell_t           data_q;

	always_comb begin
		rem_sh = {din.rem[RemW-2:0], din.num[NumW-1]};
		ge     = (rem_sh >= {1'b0, din.dvs});
		nxt    = din;
		nxt.rem = ge ? (rem_sh - {1'b0, din.dvs}) : rem_sh;
		nxt.quo = {din.quo[DenW-2:0], ge};
		nxt.num = {din.num[NumW-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q <= nxt;
		end
	end

	// The valid flag comes from the reset register, the data from the other.
	always_comb begin
		dout     = data_q;
		dout.vld = vld_q;
	end

endmodule
`default_nettype wire

// ----- design/restoring_divider_16_32_top.sv -----
`default_nettype none
// Path: the operand register loads at the input transfer, the work then
// passes through the 32 restoring cells in order, and the output register
// takes the result last. Each dividend bit has its own cell.
// Throughput: one division per cycle while the chain is not held.
// Reset: arst_n clears all valid flags asynchronously; data registers keep
// whatever they hold.
// ----------------------------------------------------------------------------
// restoring_divider_16_32_top
// Pipelined restoring shift-subtract divider, 32 by 16 bits, with unsigned
// 16/16, unsigned 32/16 and signed 16/16 modes.
// ----------------------------------------------------------------------------
module restoring_divider_16_32_top (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            req_valid,
	output logic           req_ready,
	input  rdiv_pkg::req_t req_data,
	output logic           rsp_valid,
	input  wire            rsp_ready,
	output rdiv_pkg::rsp_t rsp_data
);
	import rdiv_pkg::*;

	// The chain moves as one. It only holds when the last cell has a result
	// that cannot enter the output register because a previous result there
	// has not been taken yet. A waiting result therefore does not stop new
	// transfers while the last cell is empty.
	logic  adv;
	cell_t chain [0:NumW];
	cell_t last;

	// Operand preparation.
	logic            is_signed;
	logic [DenW-1:0] a_lo;
	logic            na;
	logic            nb;
	logic [DenW-1:0] ma;
	logic [DenW-1:0] mb;
	cell_t           prep;
	logic            op_vld_s0;
	cell_t           op_dat_s0;
	cell_t           op_s0;

	always_comb begin
		is_signed = req_data.command[1];
		a_lo      = req_data.dividend[DenW-1:0];
		na        = is_signed & a_lo[DenW-1];
		nb        = is_signed & req_data.divisor[DenW-1];
		// The negation of the most negative value wraps to itself, which is
		// exactly its magnitude read as unsigned.
		ma        = na ? (~a_lo + 1'b1) : a_lo;
		mb        = nb ? (~req_data.divisor + 1'b1) : req_data.divisor;
		prep.vld  = 1'b1;
		prep.rem  = '0;
		prep.quo  = '0;
		if (is_signed) begin
			prep.num = {{(NumW-DenW){1'b0}}, ma};
		end else if (cmd_e'(req_data.command) == CMD_U32) begin
			prep.num = req_data.dividend;
		end else begin
			prep.num = {{(NumW-DenW){1'b0}}, a_lo};
		end
		prep.dvs   = mb;
		prep.neg_q = na ^ nb;
		prep.neg_r = na;
		prep.ok    = (req_data.divisor != '0);
	end

	assign req_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_vld_s0 <= 1'b0;
		end else if (adv) begin
			op_vld_s0 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_dat_s0 <= prep;
		end
	end

	// The stage is valid only when a transfer was taken at the last move.
	always_comb begin
		op_s0     = op_dat_s0;
		op_s0.vld = op_vld_s0;
	end

	assign chain[0] = op_s0;

	// One cell per dividend bit, most significant bit first. Only the low 16
	// quotient bits survive, as the 32/16 mode truncates its quotient.
	for (genvar g = 0; g < NumW; g++) begin : g_cell
		rdiv_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.din    (chain[g]),
			.dout   (chain[g+1])
		);
	end

	assign last = chain[NumW];
	assign adv  = !(last.vld && rsp_valid && !rsp_ready);

	// Sign fix-up and divide-by-zero handling ahead of the output register.
	// The quotient is negated when the operand signs differ, and the
	// remainder takes the sign of the dividend.
	rsp_t            fix;
	logic [DenW-1:0] r16;

	always_comb begin
		r16 = last.rem[DenW-1:0];
		fix.valid_result = last.ok;
		if (last.ok) begin
			fix.quotient  = last.neg_q ? (~last.quo + 1'b1) : last.quo;
			fix.remainder = last.neg_r ? (~r16 + 1'b1) : r16;
		end else begin
			fix.quotient  = '0;
			fix.remainder = '0;
		end
	end

	logic rsp_vld_q;
	rsp_t rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (last.vld && adv) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (last.vld && adv) begin
			rsp_q <= fix;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp_data  = rsp_q;

`ifndef SYNTH
	// A finished cell with a nonzero divisor holds a remainder below the divisor.
	a_rem_below_dvs : assert property (@(posedge clk) disable iff (!arst_n)
		(last.vld && last.ok) |-> (last.rem < {1'b0, last.dvs}))
		else $error("partial remainder not below divisor");

	// A divide by zero reports a zero quotient and remainder.
	a_zero_div : assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_data.valid_result) |->
		(rsp_data.quotient == '0 && rsp_data.remainder == '0))
		else $error("divide by zero result not cleared");

	// A result never drops without being transferred.
	a_no_drop : assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid)
		else $error("result dropped before transfer");
`endif

endmodule
`default_nettype wire

// ----- bench/tb_restoring_divider_16_32_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_restoring_divider_16_32_top
// Self-checking bench for the pipelined 32-by-16 restoring divider. Division
// requests are queued by a stimulus process and sent by a clocked driver. Each
// accepted request is divided in the bench by shift and subtract, and the
// expected quotient, remainder and flag wait in order until the clocked
// monitor sees the matching response transfer.
// ----------------------------------------------------------------------------
module tb_restoring_divider_16_32_top;

	import rdiv_pkg::*;

	// A watchdog ends the run after this many cycles without any transfer.
	// The slowest correct stretch is the pipeline latency plus a long receiver
	// stall, well below this.
	localparam int unsigned STALL_LIMIT  = 2000;
	// Cycles to watch after the last response, a little over the latency.
	localparam int unsigned TAIL_CYCLES  = 40;
	localparam int unsigned RANDOM_BATCH = 300;
	localparam int unsigned REPORT_MAX   = 10;

	// An accepted request together with the response it must produce.
	typedef struct packed {
		req_t op;
		rsp_t want;
	} division_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic rsp_ready = 1'b0;
	req_t req_data  = '0;
	logic req_ready;
	logic rsp_valid;
	rsp_t rsp_data;

	req_t      operands_to_send [$];
	division_t awaited_quotients [$];
	division_t oldest;

	int unsigned sender_idle_pct   = 38;
	int unsigned receiver_idle_pct = 52;
	int unsigned failures          = 0;
	int unsigned quiet_cycles      = 0;

	restoring_divider_16_32_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	always #6 clk = ~clk;

	// Bench-side divider. The magnitudes are divided one bit at a time with a
	// 17-bit partial remainder, exactly as a restoring array does it, so the
	// quotient of an overflowing 32/16 division wraps to its low 16 bits.
	// In signed mode the quotient is negated when the operand signs differ and
	// the remainder takes the sign of the dividend. The most negative dividend
	// keeps its pattern 0x8000 as magnitude, which is why -32768 / -1 comes
	// back as 0x8000 with remainder 0.
	function automatic rsp_t compute_division(input req_t op);
		rsp_t        res;
		logic [31:0] num;
		logic [15:0] den;
		logic [16:0] part;
		logic [15:0] quo;
		logic        a_neg;
		logic        b_neg;
		res = '0;
		if (op.divisor == 16'h0000) begin
			return res;
		end
		// Only bit 1 selects signed operation, so the spare code is signed too.
		a_neg = op.command[1] & op.dividend[15];
		b_neg = op.command[1] & op.divisor[15];
		den = b_neg ? (~op.divisor + 1'b1) : op.divisor;
		if (op.command == CMD_U32) begin
			num = op.dividend;
		end else begin
			num = {16'h0000, a_neg ? (~op.dividend[15:0] + 1'b1) : op.dividend[15:0]};
		end
		part = '0;
		quo = '0;
		for (int i = 31; i >= 0; i--) begin
			part = {part[15:0], num[i]};
			quo = {quo[14:0], 1'b0};
			if (part >= {1'b0, den}) begin
				part = part - {1'b0, den};
				quo[0] = 1'b1;
			end
		end
		res.quotient = (a_neg != b_neg) ? (~quo + 1'b1) : quo;
		res.remainder = a_neg ? (~part[15:0] + 1'b1) : part[15:0];
		res.valid_result = 1'b1;
		return res;
	endfunction

	// Random request. Commands, divisor shapes and dividend shapes are mixed so
	// that zero divisors, the edges of the signed range, overflowing and
	// in-range 32/16 divisions and ignored upper dividend bits all show up.
	function automatic req_t random_operands();
		req_t        op;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 3) begin
			op.command = CMD_U16;
		end else if (pick < 6) begin
			op.command = CMD_U32;
		end else if (pick < 9) begin
			op.command = CMD_S16;
		end else begin
			op.command = CMD_RSV;
		end
		case ($urandom_range(0, 3))
			0: op.divisor = 16'($urandom);
			1: op.divisor = 16'($urandom_range(1, 16));
			2: begin
				case ($urandom_range(0, 4))
					0: op.divisor = 16'h0000;
					1: op.divisor = 16'h0001;
					2: op.divisor = 16'hFFFF;
					3: op.divisor = 16'h8000;
					default: op.divisor = 16'h7FFF;
				endcase
			end
			default: op.divisor = 16'($urandom) >> $urandom_range(0, 15);
		endcase
		case ($urandom_range(0, 4))
			0: op.dividend = $urandom;
			1: op.dividend = $urandom_range(0, 255);
			2: begin
				case ($urandom_range(0, 5))
					0: op.dividend = 32'h0000_0000;
					1: op.dividend = 32'hFFFF_FFFF;
					2: op.dividend = 32'h8000_0000;
					3: op.dividend = 32'h0000_8000;
					4: op.dividend = 32'h0000_FFFF;
					default: op.dividend = 32'h0000_7FFF;
				endcase
			end
			3: begin
				// A 32/16 division whose quotient fits in 16 bits.
				op.dividend = {16'h0000, op.divisor} * $urandom_range(0, 65535);
				if (op.divisor != 16'h0000) begin
					op.dividend = op.dividend + $urandom_range(0, op.divisor - 1);
				end
			end
			default: op.dividend = {16'($urandom), 16'h8000 + 16'($urandom_range(0, 3))};
		endcase
		return op;
	endfunction

	task automatic queue_division(input cmd_e cmd, input logic [31:0] dvd,
			input logic [15:0] dvs);
		req_t op;
		op.command = cmd;
		op.dividend = dvd;
		op.divisor = dvs;
		operands_to_send.push_back(op);
	endtask

	// Returns once every queued request has been sent and every response has
	// come back. The sender has nothing to offer meanwhile, so this is also
	// where it pauses until the pipeline is empty.
	task automatic wait_for_empty_pipeline();
		while (operands_to_send.size() != 0 || req_valid || awaited_quotients.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic report_failure(input string what);
		failures++;
		if (failures <= REPORT_MAX) begin
			$display("%s", what);
		end
	endtask

	// Driver. The request slot is free after this edge when nothing was offered
	// or the offered request is being taken right now; only then may a new one
	// be placed. Each accepted request is predicted at the moment of transfer.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				awaited_quotients.push_back('{op: req_data, want: compute_division(req_data)});
			end
			if (!req_valid || req_ready) begin
				if (operands_to_send.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					req_data <= operands_to_send.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor. Every response transfer is matched against the oldest awaited
	// result, field by field; the ready line is redrawn every cycle.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (awaited_quotients.size() == 0) begin
					report_failure($sformatf("unexpected response q=%h r=%h ok=%b",
						rsp_data.quotient, rsp_data.remainder, rsp_data.valid_result));
				end else begin
					oldest = awaited_quotients.pop_front();
					if (rsp_data.quotient !== oldest.want.quotient
							|| rsp_data.remainder !== oldest.want.remainder
							|| rsp_data.valid_result !== oldest.want.valid_result) begin
						report_failure($sformatf({"mismatch cmd=%0d dvd=%h dvs=%h: ",
							"expected q=%h r=%h ok=%b, got q=%h r=%h ok=%b"},
							oldest.op.command, oldest.op.dividend, oldest.op.divisor,
							oldest.want.quotient, oldest.want.remainder,
							oldest.want.valid_result, rsp_data.quotient,
							rsp_data.remainder, rsp_data.valid_result));
					end
				end
			end
			rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
		end
	end

	// Watchdog: a hung handshake on either side ends the run.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, sent with the sender idling more rarely than the
		// receiver. Unsigned 16/16: extremes, zero divisor, and upper dividend
		// bits that must be ignored.
		queue_division(CMD_U16, 32'h0000_0000, 16'h0001);
		queue_division(CMD_U16, 32'h0000_FFFF, 16'h0001);
		queue_division(CMD_U16, 32'h0000_FFFF, 16'hFFFF);
		queue_division(CMD_U16, 32'h0000_1234, 16'h0000);
		queue_division(CMD_U16, 32'hDEAD_0007, 16'h0003);
		queue_division(CMD_U16, 32'hFFFF_FFFF, 16'h0100);
		// Unsigned 32/16: quotient overflow wraps, an exact maximal quotient,
		// and a zero divisor.
		queue_division(CMD_U32, 32'hFFFF_FFFF, 16'h0001);
		queue_division(CMD_U32, 32'hFFFF_FFFF, 16'hFFFF);
		queue_division(CMD_U32, 32'h0001_0000, 16'h0001);
		queue_division(CMD_U32, 32'hFFFE_0001, 16'hFFFF);
		queue_division(CMD_U32, 32'h8000_0000, 16'h8000);
		queue_division(CMD_U32, 32'h1234_5678, 16'h0000);
		// Signed 16/16: the most negative dividend over minus one, the mixed-sign
		// and both-negative combinations, a zero dividend, and a zero divisor with upper bits set.
		queue_division(CMD_S16, 32'h0000_8000, 16'hFFFF);
		queue_division(CMD_S16, 32'h0000_8000, 16'h0001);
		queue_division(CMD_S16, 32'h0000_7FFF, 16'h8000);
		queue_division(CMD_S16, 32'h0000_FFF9, 16'h0002);
		queue_division(CMD_S16, 32'h0000_0007, 16'hFFFE);
		queue_division(CMD_S16, 32'hFFFF_FFF9, 16'hFFFE);
		queue_division(CMD_S16, 32'h0000_0000, 16'h8000);
		queue_division(CMD_S16, 32'h1234_8000, 16'h0000);
		queue_division(CMD_S16, 32'h0000_8000, 16'h8000);
		// The spare command code must act as signed 16/16.
		queue_division(CMD_RSV, 32'h0000_FFF9, 16'h0002);
		queue_division(CMD_RSV, 32'h0000_0064, 16'h0000);
		queue_division(CMD_RSV, 32'h0000_8000, 16'hFFFF);
		wait_for_empty_pipeline();

		// Random batches with three idling profiles; each batch drains the
		// pipeline completely before the next one starts.
		for (int b = 0; b < 3; b++) begin
			case (b)
				0: begin
					sender_idle_pct = 38;
					receiver_idle_pct = 52;
				end
				1: begin
					sender_idle_pct = 52;
					receiver_idle_pct = 38;
				end
				default: begin
					sender_idle_pct = 0;
					receiver_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < RANDOM_BATCH; n++) begin
				operands_to_send.push_back(random_operands());
			end
			wait_for_empty_pipeline();
		end

		// Keep watching for stray responses a little longer than the latency.
		repeat (TAIL_CYCLES) @(negedge clk);
		if (failures == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ----- files.f -----
design/rdiv_pkg.sv
design/rdiv_cell.sv
design/restoring_divider_16_32_top.sv
bench/tb_restoring_divider_16_32_top.sv
